@@ design/gtri_pkg.sv @@
// shared types, constants and helpers for the grid edge triangle intersect unit
`timescale 1ns / 1ps
package gtri_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int LEN_W   = 31;
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 68;
   localparam int ACC_W   = 104;
   localparam int SPLIT_W = 33;
   localparam int NRM_W   = 67;
   localparam int DEN_W   = 99;
   localparam int DIST_W  = 102;
   localparam int NUM_W   = 100;
   localparam int DVS_W   = 68;
   localparam int QUO_W   = 32;
   localparam int CNT_W   = 5;
   localparam int STEP_W  = 5;

   localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(21);
   localparam logic [DEN_W-1:0]  PARALLEL_LIMIT = DEN_W'(281475);
   localparam logic [LEN_W-1:0]  LEN_RESET      = LEN_W'(65536);

   localparam logic       OP_LOAD = 1'b0;
   localparam logic       OP_TEST = 1'b1;
   localparam logic [1:0] AXIS_X  = 2'd0;
   localparam logic [1:0] AXIS_Y  = 2'd1;
   localparam logic [1:0] AXIS_Z  = 2'd2;
   localparam logic [1:0] SLOT_NONE = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DECIDE,
      S_DIV,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_N0,
      DST_N1,
      DST_N2,
      DST_DEN,
      DST_DIST,
      DST_C0,
      DST_C1,
      DST_C2
   } dst_type;

   typedef struct packed {
      logic    issue;
      logic    clr;
      logic    sub;
      logic    sh;
      dst_type dst;
   } mac_op_type;

   typedef struct packed {
      dst_type                   dst;
      logic signed [ACC_W-1:0]   value;
   } mac_res_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } dvec_type;

   function automatic dvec_type vsub(vec_type a, vec_type b);
      dvec_type r;
      r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
      r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
      r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
      return r;
   endfunction

   function automatic logic signed [DIFF_W-1:0] dpick(dvec_type v, logic [1:0] k);
      logic signed [DIFF_W-1:0] r;
      case (k)
         AXIS_X:  r = v.x;
         AXIS_Y:  r = v.y;
         AXIS_Z:  r = v.z;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] vpick(vec_type v, logic [1:0] k);
      logic signed [COORD_W-1:0] r;
      case (k)
         AXIS_X:  r = v.x;
         AXIS_Y:  r = v.y;
         AXIS_Z:  r = v.z;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] axis_u(logic [1:0] a);
      logic [1:0] r;
      case (a)
         AXIS_X:  r = AXIS_Y;
         AXIS_Y:  r = AXIS_Z;
         default: r = AXIS_X;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] axis_w(logic [1:0] a);
      logic [1:0] r;
      case (a)
         AXIS_X:  r = AXIS_Z;
         AXIS_Y:  r = AXIS_X;
         default: r = AXIS_Y;
      endcase
      return r;
   endfunction

endpackage

@@ design/gtri_ifs.sv @@
// request, response and csr channel interfaces
`timescale 1ns / 1ps
interface gtri_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [1:0]                           vertex_slot;
   logic signed [gtri_pkg::COORD_W-1:0]  coord_x;
   logic signed [gtri_pkg::COORD_W-1:0]  coord_y;
   logic signed [gtri_pkg::COORD_W-1:0]  coord_z;
   logic [1:0]                           edge_axis;
   modport source (output valid, operation, vertex_slot, coord_x, coord_y, coord_z,
                   edge_axis, input ready);
   modport sink (input valid, operation, vertex_slot, coord_x, coord_y, coord_z,
                 edge_axis, output ready);
endinterface

interface gtri_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [gtri_pkg::COORD_W-1:0]  point_x;
   logic signed [gtri_pkg::COORD_W-1:0]  point_y;
   logic signed [gtri_pkg::COORD_W-1:0]  point_z;
   logic                                 normal_aligned;
   modport source (output valid, hit, point_x, point_y, point_z, normal_aligned,
                   input ready);
   modport sink (input valid, hit, point_x, point_y, point_z, normal_aligned,
                 output ready);
endinterface

interface gtri_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gtri_pkg::LEN_W-1:0]      edge_length;
   modport source (output valid, edge_length, input ready);
   modport sink (input valid, edge_length, output ready);
endinterface

@@ design/gtri_mac.sv @@
// shared multiply-accumulate unit: registered 34x34 product, then shifted accumulate
`timescale 1ns / 1ps
module gtri_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gtri_pkg::mac_op_type                   op,
   input  logic signed [gtri_pkg::MUL_W-1:0]      opa,
   input  logic signed [gtri_pkg::MUL_W-1:0]      opb,
   output gtri_pkg::mac_res_type                  res
);
   logic signed [gtri_pkg::PROD_W-1:0] prod_ff;
   gtri_pkg::mac_op_type               op_ff;
   logic signed [gtri_pkg::ACC_W-1:0]  acc_ff;
   logic signed [gtri_pkg::ACC_W-1:0]  acc_in;
   logic signed [gtri_pkg::ACC_W-1:0]  shifted;
   logic signed [gtri_pkg::ACC_W-1:0]  term;

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      if (reset) begin
         op_ff <= '0;
      end else begin
         op_ff <= op;
      end
      if (op_ff.issue) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      shifted = gtri_pkg::ACC_W'(prod_ff);
      if (op_ff.sh) begin
         shifted = shifted <<< gtri_pkg::SPLIT_W;
      end
      term   = op_ff.sub ? -shifted : shifted;
      acc_in = (op_ff.clr ? '0 : acc_ff) + term;
      res.value = acc_in;
      res.dst   = op_ff.issue ? op_ff.dst : gtri_pkg::DST_NONE;
   end
endmodule

@@ design/gtri_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gtri_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [gtri_pkg::NUM_W-1:0]       num,
   input  logic [gtri_pkg::DVS_W-1:0]       divisor,
   output logic                             done,
   output logic [gtri_pkg::QUO_W-1:0]       quo
);
   logic [gtri_pkg::NUM_W-1:0] r_ff;
   logic [gtri_pkg::NUM_W-1:0] d_ff;
   logic [gtri_pkg::QUO_W-1:0] q_ff;
   logic [gtri_pkg::CNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [gtri_pkg::NUM_W:0]   diff;
   logic                       fits;

   assign diff = {1'b0, r_ff} - {1'b0, d_ff};
   assign fits = !diff[gtri_pkg::NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == gtri_pkg::CNT_W'(gtri_pkg::QUO_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         r_ff <= num;
         d_ff <= gtri_pkg::NUM_W'({divisor, {(gtri_pkg::QUO_W - 1){1'b0}}});
         q_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            r_ff <= diff[gtri_pkg::NUM_W-1:0];
         end
         q_ff <= {q_ff[gtri_pkg::QUO_W-2:0], fits};
         d_ff <= d_ff >> 1;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

@@ design/grid_edge_triangle_intersect_unit.sv @@
// top level: grid edge against stored triangle, sequencer around a shared mac and a divider
// a vertex load gives no response
// an edge test answers on a miss or a hit; an edge axis of three goes straight to the done state as a miss
// a test runs the mac program, a decide state, on a hit the divider, then a done state
// one request at a time: the next is taken back in idle, once the response is loaded; a response stall holds done
// reset (synchronous, active high) clears the triangle to zeros and edge_length to 1.0
`timescale 1ns / 1ps
module grid_edge_triangle_intersect_unit (
   input  logic        clock,
   input  logic        reset,
   gtri_req_if.sink    req_ch,
   gtri_rsp_if.source  rsp_ch,
   gtri_csr_if.sink    csr_ch
);
   // control
   gtri_pkg::state_type                state_ff, state_in;
   logic [gtri_pkg::STEP_W-1:0]        step_ff;
   logic                               req_fire;
   logic                               div_start;
   logic                               div_done;
   logic [gtri_pkg::QUO_W-1:0]         div_quo;

   // operands and intermediate results
   gtri_pkg::vec_type                  v_ff [3];
   gtri_pkg::vec_type                  p_ff;
   logic [1:0]                         axis_ff;
   logic [gtri_pkg::LEN_W-1:0]         len_ff;
   logic signed [gtri_pkg::NRM_W-1:0]  n_ff [3];
   logic signed [gtri_pkg::DEN_W-1:0]  den_ff;
   logic signed [gtri_pkg::DIST_W-1:0] dist_ff;
   logic [2:0]                         cneg_ff;
   logic [2:0]                         czero_ff;

   // pending result and output register
   logic                               res_hit_ff;
   gtri_pkg::vec_type                  res_pt_ff;
   logic                               res_aligned_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   gtri_pkg::vec_type                  rsp_pt_ff;
   logic                               rsp_aligned_ff;
   logic                               rsp_load;

   // mac interface
   gtri_pkg::mac_op_type               mop;
   logic signed [gtri_pkg::MUL_W-1:0]  opa, opb;
   gtri_pkg::mac_res_type              mres;

   // combinational helpers
   gtri_pkg::dvec_type                 e1, e2, dv, ea, eb;
   gtri_pkg::vec_type                  vj, vm;
   logic [1:0]                         au, aw;
   logic signed [gtri_pkg::NRM_W-1:0]  nsel;
   logic                               nneg;
   logic [gtri_pkg::DEN_W-1:0]         absden;
   logic signed [gtri_pkg::DIST_W-1:0] distn;
   logic [gtri_pkg::NRM_W-1:0]         nam;
   logic                               aligned;
   logic                               miss;
   logic [gtri_pkg::NUM_W-1:0]         div_num;
   logic [gtri_pkg::DVS_W-1:0]         div_dvs;
   logic signed [gtri_pkg::COORD_W+1:0] pa_sum;
   logic signed [gtri_pkg::COORD_W-1:0] pa_sat;
   gtri_pkg::vec_type                  hit_pt;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == gtri_pkg::S_IDLE);
   assign csr_ch.ready = 1'b1;

   // edge vectors of the triangle and offsets from the edge start
   assign e1 = gtri_pkg::vsub(v_ff[1], v_ff[0]);
   assign e2 = gtri_pkg::vsub(v_ff[2], v_ff[0]);
   assign dv = gtri_pkg::vsub(v_ff[0], p_ff);
   assign au = gtri_pkg::axis_u(axis_ff);
   assign aw = gtri_pkg::axis_w(axis_ff);
   assign nsel = n_ff[axis_ff];

   // sub-triangle corners for the barycentric signs
   always_comb begin
      case (step_ff) inside
         5'd15, 5'd16: begin vj = v_ff[1]; vm = v_ff[2]; end
         5'd17, 5'd18: begin vj = v_ff[2]; vm = v_ff[0]; end
         default:      begin vj = v_ff[0]; vm = v_ff[1]; end
      endcase
      ea = gtri_pkg::vsub(vm, vj);
      eb = gtri_pkg::vsub(p_ff, vj);
   end

   // mac program: normal, denominator, plane distance, three barycentric crosses
   // wide normal components go in as a 33-bit low half and a signed high half
   always_comb begin
      mop = '0;
      opa = '0;
      opb = '0;
      if (state_ff == gtri_pkg::S_MAC) begin
         mop.issue = 1'b1;
         case (step_ff)
            5'd0:  begin opa = 34'(e1.y); opb = 34'(e2.z); mop.clr = 1'b1; end
            5'd1:  begin opa = 34'(e1.z); opb = 34'(e2.y); mop.sub = 1'b1;
                         mop.dst = gtri_pkg::DST_N0; end
            5'd2:  begin opa = 34'(e1.z); opb = 34'(e2.x); mop.clr = 1'b1; end
            5'd3:  begin opa = 34'(e1.x); opb = 34'(e2.z); mop.sub = 1'b1;
                         mop.dst = gtri_pkg::DST_N1; end
            5'd4:  begin opa = 34'(e1.x); opb = 34'(e2.y); mop.clr = 1'b1; end
            5'd5:  begin opa = 34'(e1.y); opb = 34'(e2.x); mop.sub = 1'b1;
                         mop.dst = gtri_pkg::DST_N2; end
            5'd7:  begin opa = $signed({1'b0, nsel[32:0]}); opb = $signed({3'b0, len_ff});
                         mop.clr = 1'b1; end
            5'd8:  begin opa = nsel[66:33]; opb = $signed({3'b0, len_ff}); mop.sh = 1'b1;
                         mop.dst = gtri_pkg::DST_DEN; end
            5'd9:  begin opa = $signed({1'b0, n_ff[0][32:0]}); opb = 34'(dv.x);
                         mop.clr = 1'b1; end
            5'd10: begin opa = n_ff[0][66:33]; opb = 34'(dv.x); mop.sh = 1'b1; end
            5'd11: begin opa = $signed({1'b0, n_ff[1][32:0]}); opb = 34'(dv.y); end
            5'd12: begin opa = n_ff[1][66:33]; opb = 34'(dv.y); mop.sh = 1'b1; end
            5'd13: begin opa = $signed({1'b0, n_ff[2][32:0]}); opb = 34'(dv.z); end
            5'd14: begin opa = n_ff[2][66:33]; opb = 34'(dv.z); mop.sh = 1'b1;
                         mop.dst = gtri_pkg::DST_DIST; end
            5'd15, 5'd17, 5'd19: begin
               opa = 34'(gtri_pkg::dpick(ea, au));
               opb = 34'(gtri_pkg::dpick(eb, aw));
               mop.clr = 1'b1;
            end
            5'd16, 5'd18, 5'd20: begin
               opa = 34'(gtri_pkg::dpick(ea, aw));
               opb = 34'(gtri_pkg::dpick(eb, au));
               mop.sub = 1'b1;
               mop.dst = (step_ff == 5'd16) ? gtri_pkg::DST_C0 :
                         (step_ff == 5'd18) ? gtri_pkg::DST_C1 : gtri_pkg::DST_C2;
            end
            default: mop.issue = 1'b0; // bubbles waiting on the accumulator
         endcase
      end
   end

   gtri_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mop),
      .opa   (opa),
      .opb   (opb),
      .res   (mres)
   );

   // decision on the stored sums
   always_comb begin
      nneg    = nsel[gtri_pkg::NRM_W-1];
      absden  = den_ff[gtri_pkg::DEN_W-1] ? -den_ff : den_ff;
      aligned = !den_ff[gtri_pkg::DEN_W-1] && (den_ff != '0);
      distn   = nneg ? -dist_ff : dist_ff;
      nam     = nneg ? -nsel : nsel;
      miss    = (absden < gtri_pkg::PARALLEL_LIMIT)
             || distn[gtri_pkg::DIST_W-1]
             || (distn > $signed({3'b0, absden}))
             || (|(nneg ? (~cneg_ff & ~czero_ff) : cneg_ff));
      // rounded step: (2*dist + |n|) / (2*|n|)
      div_num = {distn[gtri_pkg::NUM_W-2:0], 1'b0} + gtri_pkg::NUM_W'(nam);
      div_dvs = {nam, 1'b0};
   end

   gtri_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .divisor (div_dvs),
      .done    (div_done),
      .quo     (div_quo)
   );

   // crossing point: off-axis coordinates from the start, edge-axis coordinate saturated upward
   always_comb begin
      pa_sum = 34'(gtri_pkg::vpick(p_ff, axis_ff)) + $signed({2'b0, div_quo});
      pa_sat = (pa_sum > 34'sd2147483647) ? 32'sh7fffffff : pa_sum[31:0];
      hit_pt = p_ff;
      case (axis_ff)
         gtri_pkg::AXIS_X: hit_pt.x = pa_sat;
         gtri_pkg::AXIS_Y: hit_pt.y = pa_sat;
         default:          hit_pt.z = pa_sat;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         gtri_pkg::S_IDLE: begin
            if (req_fire && req_ch.operation == gtri_pkg::OP_TEST) begin
               if (req_ch.edge_axis == gtri_pkg::AXIS_X || req_ch.edge_axis == gtri_pkg::AXIS_Y
                   || req_ch.edge_axis == gtri_pkg::AXIS_Z) begin
                  state_in = gtri_pkg::S_MAC;
               end else begin
                  state_in = gtri_pkg::S_DONE;
               end
            end
         end
         gtri_pkg::S_MAC: begin
            if (step_ff == gtri_pkg::STEP_LAST) state_in = gtri_pkg::S_DECIDE;
         end
         gtri_pkg::S_DECIDE: begin
            if (miss) begin
               state_in = gtri_pkg::S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = gtri_pkg::S_DIV;
            end
         end
         gtri_pkg::S_DIV: begin
            if (div_done) state_in = gtri_pkg::S_DONE;
         end
         gtri_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = gtri_pkg::S_IDLE;
            end
         end
         default: state_in = gtri_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtri_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (state_ff == gtri_pkg::S_MAC) begin
         step_ff <= step_ff + 1'b1;
      end else begin
         step_ff <= '0;
      end
   end

   // triangle and edge length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= '0;
         v_ff[1] <= '0;
         v_ff[2] <= '0;
         len_ff  <= gtri_pkg::LEN_RESET;
      end else begin
         if (req_fire && req_ch.operation == gtri_pkg::OP_LOAD
             && req_ch.vertex_slot != gtri_pkg::SLOT_NONE) begin
            v_ff[req_ch.vertex_slot] <= {req_ch.coord_x, req_ch.coord_y, req_ch.coord_z};
         end
         if (csr_ch.valid && csr_ch.ready) begin
            len_ff <= csr_ch.edge_length;
         end
      end
   end

   // test request capture, mac writebacks and the pending result
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.operation == gtri_pkg::OP_TEST) begin
         p_ff           <= {req_ch.coord_x, req_ch.coord_y, req_ch.coord_z};
         axis_ff        <= req_ch.edge_axis;
         res_hit_ff     <= 1'b0;
         res_pt_ff      <= '0;
         res_aligned_ff <= 1'b0;
      end
      case (mres.dst)
         gtri_pkg::DST_N0:   n_ff[0] <= mres.value[gtri_pkg::NRM_W-1:0];
         gtri_pkg::DST_N1:   n_ff[1] <= mres.value[gtri_pkg::NRM_W-1:0];
         gtri_pkg::DST_N2:   n_ff[2] <= mres.value[gtri_pkg::NRM_W-1:0];
         gtri_pkg::DST_DEN:  den_ff  <= mres.value[gtri_pkg::DEN_W-1:0];
         gtri_pkg::DST_DIST: dist_ff <= mres.value[gtri_pkg::DIST_W-1:0];
         gtri_pkg::DST_C0: begin
            cneg_ff[0]  <= mres.value[gtri_pkg::ACC_W-1];
            czero_ff[0] <= (mres.value == '0);
         end
         gtri_pkg::DST_C1: begin
            cneg_ff[1]  <= mres.value[gtri_pkg::ACC_W-1];
            czero_ff[1] <= (mres.value == '0);
         end
         gtri_pkg::DST_C2: begin
            cneg_ff[2]  <= mres.value[gtri_pkg::ACC_W-1];
            czero_ff[2] <= (mres.value == '0);
         end
         default: ;
      endcase
      if (state_ff == gtri_pkg::S_DECIDE) begin
         res_aligned_ff <= aligned;
      end
      if (state_ff == gtri_pkg::S_DIV && div_done) begin
         res_hit_ff <= 1'b1;
         res_pt_ff  <= hit_pt;
      end
   end

   // output register, decoupled from the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_hit_ff     <= res_hit_ff;
         rsp_pt_ff      <= res_pt_ff;
         rsp_aligned_ff <= res_aligned_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.hit            = rsp_hit_ff;
   assign rsp_ch.point_x        = rsp_pt_ff.x;
   assign rsp_ch.point_y        = rsp_pt_ff.y;
   assign rsp_ch.point_z        = rsp_pt_ff.z;
   assign rsp_ch.normal_aligned = rsp_aligned_ff;

   // a test request blocks the next one
   a_test_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.operation == gtri_pkg::OP_TEST) |=> !req_ch.ready)
      else $error("request taken while a test is in flight");

   // a new response only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff == gtri_pkg::S_DONE))
      else $error("response raised outside the done state");

   // a miss carries a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.hit) |->
         (rsp_ch.point_x == '0 && rsp_ch.point_y == '0 && rsp_ch.point_z == '0))
      else $error("miss response with nonzero point");
endmodule

@@ sim/tb.sv @@
// self-checking testbench for the grid edge triangle intersect unit
`timescale 1ns / 1ps
module tb;

   typedef struct {
      logic              operation;
      logic [1:0]        vertex_slot;
      logic signed [31:0] cx, cy, cz;
      logic [1:0]        edge_axis;
      bit                known;
      logic              hit;
      logic signed [31:0] px, py, pz;
      logic              aligned;
   } row_type;

   typedef struct {
      logic              hit;
      logic signed [31:0] px, py, pz;
      logic              aligned;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   gtri_req_if req_ch ();
   gtri_rsp_if rsp_ch ();
   gtri_csr_if csr_ch ();

   grid_edge_triangle_intersect_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // predictor state
   logic signed [31:0]          tri_mem [3][3];
   logic [gtri_pkg::LEN_W-1:0]  len_q;

   crossing_type pending_q[$];
   int mismatches = 0;
   int hits_seen = 0;
   int checked = 0;
   int tests_sent = 0;
   longint cycles = 0;
   bit rsp_stall_on = 1'b1;

   function automatic logic signed [201:0] cross_comp(logic signed [201:0] au,
      logic signed [201:0] aw, logic signed [201:0] bu, logic signed [201:0] bw);
      return au * bw - aw * bu;
   endfunction

   // exact intersection prediction on wide signed integers
   function automatic crossing_type predict_crossing(logic signed [31:0] cx,
      logic signed [31:0] cy, logic signed [31:0] cz, logic [1:0] ax);
      crossing_type r;
      logic signed [201:0] p[3], v[3][3], e1[3], e2[3], nrm[3], den, aden;
      logic signed [201:0] plane_d, nam, c, q, pa;
      int u, w, j, m;
      r = '{1'b0, 0, 0, 0, 1'b0};
      if (ax > gtri_pkg::AXIS_Z) return r;
      p[0] = cx; p[1] = cy; p[2] = cz;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) v[i][k] = tri_mem[i][k];
      for (int k = 0; k < 3; k++) begin
         e1[k] = v[1][k] - v[0][k];
         e2[k] = v[2][k] - v[0][k];
      end
      for (int k = 0; k < 3; k++) begin
         u = (k + 1) % 3; w = (k + 2) % 3;
         nrm[k] = cross_comp(e1[u], e1[w], e2[u], e2[w]);
      end
      den = nrm[ax] * $signed({1'b0, len_q});
      r.aligned = den > 0;
      aden = den < 0 ? -den : den;
      if (aden < 281475) return r;
      plane_d = 0;
      for (int k = 0; k < 3; k++) plane_d += nrm[k] * (v[0][k] - p[k]);
      if (nrm[ax] < 0) plane_d = -plane_d;
      nam = nrm[ax] < 0 ? -nrm[ax] : nrm[ax];
      if (plane_d < 0 || plane_d > aden) return r;
      u = (ax + 1) % 3; w = (ax + 2) % 3;
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3; m = (i + 2) % 3;
         c = cross_comp(v[m][u] - v[j][u], v[m][w] - v[j][w],
                        p[u] - v[j][u], p[w] - v[j][w]);
         if (nrm[ax] < 0) c = -c;
         if (c < 0) return r;
      end
      q = (2 * plane_d + nam) / (2 * nam);
      pa = p[ax] + $signed({170'd0, q[31:0]});
      if (pa > 64'sh7FFFFFFF) pa = 64'sh7FFFFFFF;
      r.hit = 1'b1;
      r.px = cx; r.py = cy; r.pz = cz;
      case (ax)
         gtri_pkg::AXIS_X: r.px = pa[31:0];
         gtri_pkg::AXIS_Y: r.py = pa[31:0];
         default:          r.pz = pa[31:0];
      endcase
      return r;
   endfunction

   task automatic hold_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   function automatic int gap_len();
      int g;
      g = $urandom_range(0, 99);
      if (g < 50) return 0;
      if (g < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // send one request; predictor runs at acceptance, valid stays up when the next follows at once
   task automatic send_request(row_type r);
      crossing_type exp_r;
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= r.operation;
      req_ch.vertex_slot <= r.vertex_slot;
      req_ch.coord_x     <= r.cx;
      req_ch.coord_y     <= r.cy;
      req_ch.coord_z     <= r.cz;
      req_ch.edge_axis   <= r.edge_axis;
      do @(posedge clock); while (!req_ch.ready);
      if (r.operation == gtri_pkg::OP_LOAD) begin
         if (r.vertex_slot != gtri_pkg::SLOT_NONE) begin
            tri_mem[r.vertex_slot][0] = r.cx;
            tri_mem[r.vertex_slot][1] = r.cy;
            tri_mem[r.vertex_slot][2] = r.cz;
         end
      end else begin
         exp_r = predict_crossing(r.cx, r.cy, r.cz, r.edge_axis);
         // a hand-written answer stands in for the prediction
         if (r.known) exp_r = '{r.hit, r.px, r.py, r.pz, r.aligned};
         pending_q = {pending_q, exp_r};
         tests_sent++;
      end
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // write edge_length while the unit is idle
   task automatic write_length(logic [gtri_pkg::LEN_W-1:0] value);
      req_ch.valid <= 1'b0;
      wait (pending_q.size() == 0);
      hold_cycles(64);
      csr_ch.valid       <= 1'b1;
      csr_ch.edge_length <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      len_q = value;
   endtask

   // response side: random stall while rsp_stall_on is set, compare each response with the oldest expectation
   always @(posedge clock) begin
      crossing_type e;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
            end else begin
               e = pending_q.pop_front();
               checked++;
               if (rsp_ch.hit) hits_seen++;
               if (rsp_ch.hit !== e.hit || rsp_ch.point_x !== e.px ||
                   rsp_ch.point_y !== e.py || rsp_ch.point_z !== e.pz ||
                   rsp_ch.normal_aligned !== e.aligned) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp hit %0b pt %0d %0d %0d al %0b, %s %0d %0d %0d %0b",
                        e.hit, e.px, e.py, e.pz, e.aligned, "got", rsp_ch.hit,
                        rsp_ch.point_x, rsp_ch.point_y, rsp_ch.point_z,
                        rsp_ch.normal_aligned);
               end
            end
         end
         rsp_ch.ready <= rsp_stall_on ? ($urandom_range(0, 99) < 70) : 1'b1;
      end
      if (cycles > 3000000) begin
         $display("timeout with %0d responses outstanding", pending_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic row_type load_row(logic [1:0] slot, int x, int y, int z);
      return '{gtri_pkg::OP_LOAD, slot, x, y, z, gtri_pkg::AXIS_X, 1'b0, 1'b0, 0, 0, 0, 1'b0};
   endfunction

   function automatic row_type test_row(int x, int y, int z, logic [1:0] ax);
      return '{gtri_pkg::OP_TEST, 2'($urandom_range(0, 3)), x, y, z, ax,
               1'b0, 1'b0, 0, 0, 0, 1'b0};
   endfunction

   // small random coordinate near a unit cell
   function automatic int near_coord();
      return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
   endfunction

   function automatic int any_coord();
      int c;
      case ($urandom_range(0, 5))
         0: c = 32'sh7FFFFFFF;
         1: c = 32'sh80000000;
         2: c = $urandom;
         default: c = near_coord();
      endcase
      return c;
   endfunction

   row_type directed[$];
   row_type r;
   logic [1:0] ax;

   initial begin
      req_ch.valid = 1'b0; req_ch.operation = gtri_pkg::OP_LOAD; req_ch.vertex_slot = 2'd0;
      req_ch.coord_x = 0; req_ch.coord_y = 0; req_ch.coord_z = 0;
      req_ch.edge_axis = gtri_pkg::AXIS_X;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.edge_length = '0;
      for (int i = 0; i < 3; i++) for (int k = 0; k < 3; k++) tri_mem[i][k] = 0;
      len_q = gtri_pkg::LEN_RESET;
      hold_cycles(12);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate triangle right after reset: miss with all zeros
      r = test_row(0, 0, 0, gtri_pkg::AXIS_Z); r.known = 1'b1; directed = {directed, r};
      // unit triangle in z = 0.5 plane, z edge from 0 crosses at (0.25,0.25,0.5)
      directed = {directed, load_row(2'd0, 0, 0, 32768)};
      directed = {directed, load_row(2'd1, 65536, 0, 32768)};
      directed = {directed, load_row(2'd2, 0, 65536, 32768)};
      directed = {directed, load_row(gtri_pkg::SLOT_NONE, 32'sh7FFFFFFF, 32'sh80000000, 5)};
      r = test_row(16384, 16384, 0, gtri_pkg::AXIS_Z); r.known = 1'b1;
      r.hit = 1'b1; r.px = 16384; r.py = 16384; r.pz = 32768; r.aligned = 1'b1;
      directed = {directed, r};
      r = test_row(0, 0, 0, gtri_pkg::AXIS_Z); directed = {directed, r};          // vertex corner
      r = test_row(65536, 65536, 0, gtri_pkg::AXIS_Z); directed = {directed, r};  // outside
      r = test_row(16384, 16384, 32768, gtri_pkg::AXIS_Z); directed = {directed, r}; // step zero
      r = test_row(16384, 16384, -32768, gtri_pkg::AXIS_Z); directed = {directed, r}; // step one
      r = test_row(16384, 16384, 0, gtri_pkg::AXIS_X); directed = {directed, r};  // parallel
      // axis three
      r = test_row(1, 2, 3, 2'd3); r.known = 1'b1; directed = {directed, r};
      r = test_row(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, gtri_pkg::AXIS_Y);
      directed = {directed, r};
      // reversed winding, crossing near top of range
      directed = {directed, load_row(2'd0, 0, 0, 32'sh7FFFFFF0)};
      directed = {directed, load_row(2'd1, 0, 65536, 32'sh7FFFFFF0)};
      directed = {directed, load_row(2'd2, 65536, 0, 32'sh7FFFFFF0)};
      r = test_row(1000, 1000, 32'sh7FFF0000, gtri_pkg::AXIS_Z); directed = {directed, r};
      r = test_row(32'sh80000000, 32'sh80000000, 32'sh80000000, gtri_pkg::AXIS_Z);
      directed = {directed, r};
      foreach (directed[i]) send_request(directed[i]);

      // several edge lengths, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_length(gtri_pkg::LEN_W'(1));
            1: write_length(gtri_pkg::LEN_W'(65536));
            2: write_length(gtri_pkg::LEN_W'(31'h7FFFFFFF));
            3: write_length(gtri_pkg::LEN_W'($urandom_range(1, 8 * 65536)));
            4: write_length(gtri_pkg::LEN_W'($urandom));
            default: write_length(gtri_pkg::LEN_W'(65536 * 2));
         endcase
         rsp_stall_on = (phase != 2);
         for (int t = 0; t < 175; t++) begin
            // fresh triangle mostly near the cell, sometimes at extremes
            if (t % 5 == 0) begin
               for (int s = 0; s < 3; s++) begin
                  if ($urandom_range(0, 9) == 0)
                     send_request(load_row(2'(s), any_coord(), any_coord(), any_coord()));
                  else
                     send_request(load_row(2'(s), near_coord(), near_coord(), near_coord()));
               end
            end
            ax = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0) begin
               r = '{1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom, $urandom,
                     $urandom, 2'($urandom_range(0, 3)), 1'b0, 1'b0, 0, 0, 0, 1'b0};
               send_request(r);
            end else begin
               r = test_row(near_coord(), near_coord(), near_coord(), ax);
               send_request(r);
            end
         end
      end

      req_ch.valid <= 1'b0;
      wait (pending_q.size() == 0);
      hold_cycles(100);
      $display("%0d of %0d edge tests checked, %0d hits, edge_length swept 1 to max",
               checked, tests_sent, hits_seen);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
